>>> sv/tchr_pkg.sv
// Package with shared constants and types of the thermal contact heat rate block.
`timescale 1ns / 1ps
package tchr_pkg;

  localparam int NMAX       = 4;
  localparam int MATERIALS  = 4;
  localparam int TW         = 32;
  localparam int WW         = 64;
  localparam int WTW        = 96;
  localparam int WSUM_W     = 66;
  localparam int NSUM_W     = 98;
  localparam int DVS_W      = 97;
  localparam int DIV_STAGES = 32;
  localparam int RATE_W     = 48;
  localparam int IDX_W      = $clog2(NMAX);
  localparam int LAT        = 3 + 1 + DIV_STAGES + 2;

  localparam logic [2:0] REG_INV = 3'd4;

  localparam logic [TW-1:0]     HC_RESET  = 32'h0001_0000;
  localparam logic [TW-1:0]     INV_RESET = 32'h0100_0000;
  localparam logic [RATE_W-1:0] POS_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0] NEG_MAG   = 48'h8000_0000_0000;

  typedef logic [NMAX-1:0][TW-1:0] temp_vec_t;

  typedef struct packed {
    logic [NSUM_W-1:0] rem;
    logic [DVS_W-1:0]  dvs;
    logic [TW-1:0]     quo;
    temp_vec_t         temp;
    logic              empty;
  } div_t;

endpackage

>>> sv/tchr_if.sv
// Stream interfaces for node requests and rate results.
`timescale 1ns / 1ps
interface tchr_node_if;
  logic        valid;
  logic        ready;
  logic [31:0] mass_0;
  logic [31:0] mass_1;
  logic [31:0] mass_2;
  logic [31:0] mass_3;
  logic [31:0] temperature_0;
  logic [31:0] temperature_1;
  logic [31:0] temperature_2;
  logic [31:0] temperature_3;
  modport source (output valid, mass_0, mass_1, mass_2, mass_3, temperature_0,
                  temperature_1, temperature_2, temperature_3, input ready);
  modport sink (input valid, mass_0, mass_1, mass_2, mass_3, temperature_0,
                temperature_1, temperature_2, temperature_3, output ready);
endinterface

interface tchr_rate_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] rate_0;
  logic signed [47:0] rate_1;
  logic signed [47:0] rate_2;
  logic signed [47:0] rate_3;
  logic               empty_node;
  modport source (output valid, rate_0, rate_1, rate_2, rate_3, empty_node, input ready);
  modport sink (input valid, rate_0, rate_1, rate_2, rate_3, empty_node, output ready);
endinterface

>>> sv/thermal_contact_heat_rate.sv
// Top level of the thermal contact heat rate block.
//   channel   | dir | content
//   node      | in  | mass and temperature of four materials
//   result    | out | four saturated rates and the empty node flag
//   apb       | in  | specific heats and inverse time step
// One node request is taken per cycle while the result side does not stall.
// The contact temperature is formed by a 32-stage restoring divider.
// Reset clears the valid pipeline and restores the register defaults.
// A stalled result holds the whole pipeline; node.ready follows the output register.
`timescale 1ns / 1ps
module thermal_contact_heat_rate (
  input  logic        clk,
  input  logic        rst,
  tchr_node_if.sink   node,
  tchr_rate_if.source result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [tchr_pkg::NMAX-1:0][tchr_pkg::TW-1:0] cap;
  logic [tchr_pkg::TW-1:0]                     inv;
  logic [2:0]                                  ridx;
  logic                                        en;
  logic [tchr_pkg::LAT-1:0]                    vpipe;
  tchr_pkg::temp_vec_t                         mass_v, temp_v, temp_l;
  logic [tchr_pkg::NMAX-1:0][tchr_pkg::WW-1:0]  w_l;
  logic [tchr_pkg::NMAX-1:0][tchr_pkg::WTW-1:0] wt_l;
  logic [tchr_pkg::WSUM_W-1:0]                 wsum_next;
  logic [tchr_pkg::NSUM_W-1:0]                 nsum_next;
  tchr_pkg::div_t                              chain [tchr_pkg::DIV_STAGES+1];
  logic [1:0]                                  empty_d;
  logic [tchr_pkg::NMAX-1:0][tchr_pkg::RATE_W-1:0] rate_l;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tchr_pkg::NMAX; i++) cap[i] <= tchr_pkg::HC_RESET;
      inv <= tchr_pkg::INV_RESET;
    end else if (psel && penable && pwrite) begin
      if (ridx < 3'(tchr_pkg::NMAX)) begin
        cap[ridx[tchr_pkg::IDX_W-1:0]] <= pwdata;
      end else if (ridx == tchr_pkg::REG_INV) begin
        inv <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (ridx < 3'(tchr_pkg::NMAX)) begin
      prdata = cap[ridx[tchr_pkg::IDX_W-1:0]];
    end else if (ridx == tchr_pkg::REG_INV) begin
      prdata = inv;
    end
  end

  assign en         = !result.valid || result.ready;
  assign node.ready = en;

  assign mass_v = {node.mass_3, node.mass_2, node.mass_1, node.mass_0};
  assign temp_v = {node.temperature_3, node.temperature_2, node.temperature_1,
                   node.temperature_0};

  for (genvar i = 0; i < tchr_pkg::NMAX; i++) begin : g_wlane
    if (i < tchr_pkg::MATERIALS) begin : g_on
      tchr_weight_lane u_lane (
        .clk(clk), .en(en), .mass(mass_v[i]), .cap(cap[i]), .temp(temp_v[i]),
        .w(w_l[i]), .wt(wt_l[i]), .temp_q(temp_l[i])
      );
    end else begin : g_off
      assign w_l[i]    = '0;
      assign wt_l[i]   = '0;
      assign temp_l[i] = '0;
    end
  end

  // Merge the lanes into total weight and weighted temperature sum.
  always_comb begin
    wsum_next = '0;
    nsum_next = '0;
    for (int i = 0; i < tchr_pkg::NMAX; i++) begin
      wsum_next = wsum_next + tchr_pkg::WSUM_W'(w_l[i]);
      nsum_next = nsum_next + tchr_pkg::NSUM_W'(wt_l[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].rem   <= nsum_next;
      chain[0].dvs   <= {wsum_next, 31'b0};
      chain[0].quo   <= '0;
      chain[0].temp  <= temp_l;
      chain[0].empty <= (wsum_next == '0);
    end
  end

  for (genvar k = 0; k < tchr_pkg::DIV_STAGES; k++) begin : g_div
    tchr_div_stage u_stage (.clk(clk), .en(en), .din(chain[k]), .dout(chain[k+1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      empty_d <= {empty_d[0], chain[tchr_pkg::DIV_STAGES].empty};
    end
  end

  for (genvar i = 0; i < tchr_pkg::NMAX; i++) begin : g_rlane
    if (i < tchr_pkg::MATERIALS) begin : g_on
      tchr_rate_lane u_rate (
        .clk(clk), .en(en), .tc(chain[tchr_pkg::DIV_STAGES].quo),
        .temp(chain[tchr_pkg::DIV_STAGES].temp[i]), .inv(inv), .rate(rate_l[i])
      );
    end else begin : g_off
      assign rate_l[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe        <= '0;
      result.valid <= 1'b0;
    end else if (en) begin
      vpipe        <= {vpipe[tchr_pkg::LAT-2:0], node.valid};
      result.valid <= vpipe[tchr_pkg::LAT-1];
    end
  end

  // An empty node forces every rate to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      result.empty_node <= empty_d[1];
      result.rate_0     <= empty_d[1] ? '0 : rate_l[0];
      result.rate_1     <= empty_d[1] ? '0 : rate_l[1];
      result.rate_2     <= empty_d[1] ? '0 : rate_l[2];
      result.rate_3     <= empty_d[1] ? '0 : rate_l[3];
    end
  end

`ifndef SYNTHESIS
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.empty_node |->
      result.rate_0 == 0 && result.rate_1 == 0 && result.rate_2 == 0 && result.rate_3 == 0)
    else $error("empty node result carries a nonzero rate");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("valid pipeline moved during a stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    node.ready == (!result.valid || result.ready))
    else $error("node ready does not follow the output register");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=>
      result.valid && $stable(result.rate_0) && $stable(result.empty_node))
    else $error("stalled result changed before it was taken");
`endif

endmodule

>>> sv/tchr_weight_lane.sv
// Per-material lane: weight m*c and weighted temperature w*T over three stages.
`timescale 1ns / 1ps
module tchr_weight_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tchr_pkg::TW-1:0]  mass,
  input  logic [tchr_pkg::TW-1:0]  cap,
  input  logic [tchr_pkg::TW-1:0]  temp,
  output logic [tchr_pkg::WW-1:0]  w,
  output logic [tchr_pkg::WTW-1:0] wt,
  output logic [tchr_pkg::TW-1:0]  temp_q
);

  logic [tchr_pkg::WW-1:0] w1, w2;
  logic [tchr_pkg::TW-1:0] t1, t2;
  logic [tchr_pkg::WW-1:0] p0, p1;

  // The 64 by 32 product is split into two 32 by 32 halves.
  always_ff @(posedge clk) begin
    if (en) begin
      w1     <= mass * cap;
      t1     <= temp;
      p0     <= w1[31:0] * t1;
      p1     <= w1[63:32] * t1;
      w2     <= w1;
      t2     <= t1;
      wt     <= {32'b0, p0} + {p1, 32'b0};
      w      <= w2;
      temp_q <= t2;
    end
  end

endmodule

>>> sv/tchr_div_stage.sv
// One restoring division stage that settles one quotient bit.
`timescale 1ns / 1ps
module tchr_div_stage (
  input  logic            clk,
  input  logic            en,
  input  tchr_pkg::div_t  din,
  output tchr_pkg::div_t  dout
);

  logic ge;

  assign ge = din.rem >= {1'b0, din.dvs};

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem   <= ge ? din.rem - {1'b0, din.dvs} : din.rem;
      dout.dvs   <= din.dvs >> 1;
      dout.quo   <= {din.quo[tchr_pkg::TW-2:0], ge};
      dout.temp  <= din.temp;
      dout.empty <= din.empty;
    end
  end

endmodule

>>> sv/tchr_rate_lane.sv
// Per-material rate: (Tc - T) times the inverse step, truncated and saturated.
`timescale 1ns / 1ps
module tchr_rate_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tchr_pkg::TW-1:0]     tc,
  input  logic [tchr_pkg::TW-1:0]     temp,
  input  logic [tchr_pkg::TW-1:0]     inv,
  output logic [tchr_pkg::RATE_W-1:0] rate
);

  logic                        neg1, neg2;
  logic [tchr_pkg::TW-1:0]     diff;
  logic [tchr_pkg::WW-1:0]     prod;
  logic [tchr_pkg::RATE_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= tc < temp;
      diff <= (tc < temp) ? temp - tc : tc - temp;
      prod <= diff * inv;
      neg2 <= neg1;
    end
  end

  // The magnitude is truncated toward zero before the sign is applied.
  assign mag = prod[tchr_pkg::WW-1:16];

  always_comb begin
    if (neg2) begin
      rate = (mag > tchr_pkg::NEG_MAG) ? tchr_pkg::NEG_MAG : (~mag + 1'b1);
    end else begin
      rate = mag[tchr_pkg::RATE_W-1] ? tchr_pkg::POS_MAX : mag;
    end
  end

endmodule

>>> sim/thermal_contact_heat_rate_tb.sv
// Self-checking testbench for the thermal contact heat rate block.
`timescale 1ns / 1ps
module thermal_contact_heat_rate_tb;

  typedef struct {
    logic [3:0][31:0] mass;
    logic [3:0][31:0] temp;
  } node_req_t;

  typedef struct {
    logic [3:0][47:0] rate;
    logic             empty;
  } node_rate_t;

  localparam logic [4:0] ADDR_BAD = 5'd20;

  class rate_scoreboard;
    logic [31:0] heat_cap [4];
    logic [31:0] inv_step;
    node_rate_t  pending [$];
    int          errors;
    int          checked;
    int          empties;
    int          saturated;

    function new();
      for (int i = 0; i < 4; i++) heat_cap[i] = tchr_pkg::HC_RESET;
      inv_step = tchr_pkg::INV_RESET;
    endfunction

    function void set_reg(logic [4:0] addr, logic [31:0] data);
      if (addr[4:2] < 3'd4) heat_cap[addr[3:2]] = data;
      else if (addr[4:2] == tchr_pkg::REG_INV) inv_step = data;
    endfunction

    // Weighted mean of the temperatures, then a scaled, saturated difference.
    function void note_node(node_req_t n);
      logic [65:0]  wsum;
      logic [97:0]  nsum;
      logic [63:0]  w;
      logic [97:0]  quo;
      logic [31:0]  contact;
      logic [31:0]  diff;
      logic [63:0]  mag;
      node_rate_t   exp_rate;
      wsum = '0;
      nsum = '0;
      for (int i = 0; i < 4; i++) begin
        w = {32'b0, n.mass[i]} * {32'b0, heat_cap[i]};
        wsum = wsum + {2'b0, w};
        nsum = nsum + ({34'b0, w} * {66'b0, n.temp[i]});
      end
      exp_rate.rate = '0;
      exp_rate.empty = (wsum == '0);
      if (!exp_rate.empty) begin
        quo = nsum / {32'b0, wsum};
        contact = quo[31:0];
        for (int i = 0; i < 4; i++) begin
          diff = (contact < n.temp[i]) ? n.temp[i] - contact : contact - n.temp[i];
          mag = ({32'b0, diff} * {32'b0, inv_step}) >> 16;
          if (contact < n.temp[i]) begin
            if (mag > {16'b0, tchr_pkg::NEG_MAG}) mag = {16'b0, tchr_pkg::NEG_MAG};
            exp_rate.rate[i] = -mag[47:0];
          end else begin
            if (mag > {16'b0, tchr_pkg::POS_MAX}) mag = {16'b0, tchr_pkg::POS_MAX};
            exp_rate.rate[i] = mag[47:0];
          end
        end
      end
      pending.push_back(exp_rate);
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_result(node_rate_t got);
      node_rate_t want;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.empty) empties++;
      for (int i = 0; i < 4; i++) begin
        if (got.rate[i] == tchr_pkg::POS_MAX || got.rate[i] == tchr_pkg::NEG_MAG) saturated++;
        if (got.rate[i] !== want.rate[i])
          report($sformatf("rate_%0d got %h expected %h", i, got.rate[i], want.rate[i]));
      end
      if (got.empty !== want.empty)
        report($sformatf("empty_node got %b expected %b", got.empty, want.empty));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tchr_node_if node_if ();
  tchr_rate_if rate_if ();

  thermal_contact_heat_rate dut (
    .clk     (clk),
    .rst     (rst),
    .node    (node_if),
    .result  (rate_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rate_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_left = 0;
  int sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, a long hold-off when requested.
  initial begin
    rate_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rate_if.ready <= 1'b0;
      end else if (quiet) begin
        rate_if.ready <= 1'b1;
      end else begin
        rate_if.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  always @(posedge clk) begin
    node_rate_t got;
    if (!rst && rate_if.valid && rate_if.ready) begin
      got.rate[0] = rate_if.rate_0;
      got.rate[1] = rate_if.rate_1;
      got.rate[2] = rate_if.rate_2;
      got.rate[3] = rate_if.rate_3;
      got.empty = rate_if.empty_node;
      sb.check_result(got);
    end
  end

  task apb_write(logic [4:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task send_node(node_req_t n);
    int gap;
    gap = (!quiet && $urandom_range(99) < 30) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      node_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    node_if.valid <= 1'b1;
    node_if.mass_0 <= n.mass[0];
    node_if.mass_1 <= n.mass[1];
    node_if.mass_2 <= n.mass[2];
    node_if.mass_3 <= n.mass[3];
    node_if.temperature_0 <= n.temp[0];
    node_if.temperature_1 <= n.temp[1];
    node_if.temperature_2 <= n.temp[2];
    node_if.temperature_3 <= n.temp[3];
    do @(posedge clk); while (!node_if.ready);
    sb.note_node(n);
    sent++;
  endtask

  task drain();
    node_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (tchr_pkg::LAT + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word(int style);
    case (style)
      0: return $urandom();
      1: return $urandom_range(255) << 16;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0200_0000, 32'h0080_0000);
    endcase
  endfunction

  task send_random(int count);
    node_req_t n;
    int style;
    for (int k = 0; k < count; k++) begin
      style = $urandom_range(9);
      for (int i = 0; i < 4; i++) begin
        n.mass[i] = (style < 4) ? $urandom() : rand_word($urandom_range(4));
        // Occasionally zero out a material or the whole node.
        if ($urandom_range(9) == 0 || style == 9) n.mass[i] = '0;
        n.temp[i] = (style < 5) ? $urandom() : rand_word($urandom_range(4));
      end
      send_node(n);
    end
  endtask

  task send_directed();
    node_req_t n;
    n.mass = '0;
    n.temp = '0;
    send_node(n);
    n.temp = {4{32'hFFFF_FFFF}};
    send_node(n);
    n.mass = {4{32'hFFFF_FFFF}};
    send_node(n);
    n.temp = {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    send_node(n);
    for (int i = 0; i < 4; i++) begin
      n.mass = '0;
      n.mass[i] = 32'h0000_0001;
      n.temp = {32'h0012_0000, 32'h0034_0000, 32'h0056_0000, 32'h0078_0000};
      send_node(n);
    end
    n.mass = {32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};
    n.temp = {32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h0000_0001};
    send_node(n);
    n.mass = {32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF};
    n.temp = {32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
    send_node(n);
  endtask

  initial begin
    node_if.valid = 1'b0;
    node_if.mass_0 = '0;
    node_if.mass_1 = '0;
    node_if.mass_2 = '0;
    node_if.mass_3 = '0;
    node_if.temperature_0 = '0;
    node_if.temperature_1 = '0;
    node_if.temperature_2 = '0;
    node_if.temperature_3 = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Defaults after reset.
    send_directed();
    send_random(40);
    drain();

    // Largest inverse step with tiny and huge heat capacities; drives saturation.
    apb_write(5'd0, 32'hFFFF_FFFF);
    apb_write(5'd4, 32'h0000_0001);
    apb_write(5'd8, 32'h0000_0000);
    apb_write(5'd12, 32'hFFFF_FFFF);
    apb_write(5'd16, 32'hFFFF_FFFF);
    send_directed();
    send_random(60);
    drain();

    // Zero heat capacity everywhere makes every node empty.
    for (int i = 0; i < 4; i++) apb_write(5'(4 * i), 32'h0);
    apb_write(5'd16, 32'h0000_0001);
    send_random(20);
    drain();

    // A write past the last register must change nothing.
    apb_write(ADDR_BAD, 32'hDEAD_BEEF);
    apb_write(5'd0, 32'h0002_8000);
    apb_write(5'd8, 32'h0000_4000);
    apb_write(5'd16, 32'h0);
    send_random(30);
    drain();

    // Back-to-back requests against a long result stall fill the pipeline.
    quiet = 1'b1;
    for (int i = 0; i < 4; i++) apb_write(5'(4 * i), $urandom());
    apb_write(5'd16, $urandom());
    hold_left = 300;
    send_random(120);
    drain();
    quiet = 1'b0;

    for (int p = 0; p < 3; p++) begin
      for (int i = 0; i < 4; i++) apb_write(5'(4 * i), $urandom_range(32'h0004_0000));
      apb_write(5'd16, $urandom_range(32'h1000_0000, 1));
      send_random(45);
      drain();
    end

    $display("nodes sent %0d, results checked %0d, empty nodes %0d, saturated rates %0d",
             sent, sb.checked, sb.empties, sb.saturated);
    $display("register settings covered extremes, zero inverse step and an unmapped write");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> thermal_contact_heat_rate.f
sv/tchr_pkg.sv
sv/tchr_if.sv
sv/tchr_weight_lane.sv
sv/tchr_div_stage.sv
sv/tchr_rate_lane.sv
sv/thermal_contact_heat_rate.sv
sim/thermal_contact_heat_rate_tb.sv
